FILE: src/potq_pkg.sv
// Package for the policy ordered task queue: sizes, codes, the task attribute
// record and small helpers for time and ring addressing.
// Depends on nothing; used by potq_order and policy_ordered_task_queue_core.
package potq_pkg;

  localparam int TASKS = 64;
  localparam int AW    = (TASKS > 1) ? $clog2(TASKS) : 1;
  localparam int CW    = $clog2(TASKS + 1);

  typedef logic [AW-1:0] id_t;
  typedef logic [CW-1:0] cnt_t;
  typedef logic [31:0]   tick_t;
  typedef logic [1:0]    policy_t;
  typedef logic [1:0]    req_t;
  typedef logic [1:0]    stat_t;

  typedef struct packed {
    logic signed [15:0] prio;
    logic [30:0]        deadline;
    tick_t              ready;
  } attr_t;

  localparam logic [30:0] NO_DEADLINE = 31'h7FFF_FFFF;
  localparam tick_t       TIME_MAX    = 32'hFFFF_FFFF;

  localparam req_t REQ_NEW      = 2'd0;
  localparam req_t REQ_CONT     = 2'd1;
  localparam req_t REQ_ELAPSE   = 2'd2;
  localparam req_t REQ_DISPATCH = 2'd3;

  localparam stat_t STAT_OK     = 2'd0;
  localparam stat_t STAT_EMPTY  = 2'd1;
  localparam stat_t STAT_NO_RUN = 2'd2;
  localparam stat_t STAT_FULL   = 2'd3;

  localparam policy_t POL_FIFO     = 2'd0;
  localparam policy_t POL_PRIO     = 2'd1;
  localparam policy_t POL_DEADLINE = 2'd2;

  function automatic tick_t sat_add(tick_t a, logic [15:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {17'd0, b};
    return s[32] ? TIME_MAX : s[31:0];
  endfunction

  // ring address: base plus offset, wrapped at TASKS
  function automatic id_t qwrap(id_t base, cnt_t off);
    logic [CW:0] s;
    s = {{(CW + 1 - AW){1'b0}}, base} + {1'b0, off};
    if (s >= (CW + 1)'(TASKS)) begin
      s = s - (CW + 1)'(TASKS);
    end
    return s[AW-1:0];
  endfunction

endpackage

FILE: src/potq_order.sv
// Ordering compare for the task queue: true when the key task must come
// strictly before the queued entry under the selected policy.
// Depends on potq_pkg.
module potq_order (
  input  potq_pkg::policy_t policy,
  input  potq_pkg::attr_t   key_attr,
  input  potq_pkg::id_t     key_id,
  input  potq_pkg::attr_t   ent_attr,
  input  potq_pkg::id_t     ent_id,
  output logic              key_first
);
  import potq_pkg::*;

  logic id_lt, prio_lt, prio_eq, dl_lt, dl_eq, rdy_lt, rdy_eq;

  always_comb begin
    id_lt   = key_id < ent_id;
    prio_lt = $signed(key_attr.prio) < $signed(ent_attr.prio);
    prio_eq = key_attr.prio == ent_attr.prio;
    dl_lt   = key_attr.deadline < ent_attr.deadline;
    dl_eq   = key_attr.deadline == ent_attr.deadline;
    rdy_lt  = key_attr.ready < ent_attr.ready;
    rdy_eq  = key_attr.ready == ent_attr.ready;
    case (policy)
      POL_PRIO: begin
        key_first = prio_eq ? id_lt : prio_lt;
      end
      POL_DEADLINE: begin
        if (!dl_eq) begin
          key_first = dl_lt;
        end else if (!rdy_eq) begin
          key_first = rdy_lt;
        end else if (!prio_eq) begin
          key_first = prio_lt;
        end else begin
          key_first = id_lt;
        end
      end
      default: begin
        key_first = id_lt;
      end
    endcase
  end

endmodule

FILE: src/policy_ordered_task_queue_core.sv
// Top level of the policy ordered task queue: request sequencer, ring queue
// memory, task attribute memory and the saturating time counter.
// Depends on potq_pkg and potq_order.
//
//  channel  direction  handshake            payload
//  in       input      in_valid / in_stall  req_type, task_priority, task_deadline,
//                                           has_deadline, wait_ticks, elapsed_ticks
//  out      output     out_valid / out_stall status, task_id, now_time
//  cfg      input      cfg_we               cfg_data (order policy)
//
// One transaction at a time; in_stall is high from accept until the result is
// loaded into the output register. Elapse and errors go straight to the finish
// step; dispatch reads the head entry and its attributes first. New scans the
// queue through the one compare unit and then moves the entries behind the new
// place back by one; continue first writes the running task's new ready time.
// Synchronous reset empties the queue at once; no clearing pass is needed.
// A held result (out_stall) keeps the next transaction in its finish step,
// with in_stall high, until the output register is free.
module policy_ordered_task_queue_core (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  potq_pkg::policy_t       cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  potq_pkg::req_t          req_type,
  input  logic signed [15:0]      task_priority,
  input  logic [30:0]             task_deadline,
  input  logic                    has_deadline,
  input  logic [15:0]             wait_ticks,
  input  logic [15:0]             elapsed_ticks,
  output logic                    out_valid,
  input  logic                    out_stall,
  output potq_pkg::stat_t         status,
  output potq_pkg::id_t           task_id,
  output potq_pkg::tick_t         now_time
);
  import potq_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CRD  = 4'd1;
  localparam logic [3:0] S_SQ   = 4'd2;
  localparam logic [3:0] S_SA   = 4'd3;
  localparam logic [3:0] S_SC   = 4'd4;
  localparam logic [3:0] S_SHR  = 4'd5;
  localparam logic [3:0] S_SHW  = 4'd6;
  localparam logic [3:0] S_DQ   = 4'd7;
  localparam logic [3:0] S_DA   = 4'd8;
  localparam logic [3:0] S_FIN  = 4'd9;

  logic [3:0] state;
  policy_t    order_policy;
  tick_t      now;
  cnt_t       next_id;
  logic       running_valid;
  id_t        running_task;
  cnt_t       count;
  id_t        head;
  cnt_t       pos;
  cnt_t       k;
  id_t        ins_id;
  attr_t      key_attr;
  stat_t      res_status;
  id_t        res_id;

  id_t   qmem [TASKS];
  attr_t amem [TASKS];
  id_t   q_rd;
  attr_t a_rd;

  logic  q_re, q_we, a_re, a_we;
  id_t   q_raddr, q_waddr, q_wdata, a_raddr, a_waddr;
  attr_t a_wdata;
  attr_t new_attr;
  logic  key_first;
  logic  in_acc;

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && (state == S_IDLE);

  always_comb begin
    new_attr.prio     = task_priority;
    new_attr.deadline = has_deadline ? task_deadline : NO_DEADLINE;
    new_attr.ready    = '0;
  end

  potq_order u_order (
    .policy    (order_policy),
    .key_attr  (key_attr),
    .key_id    (ins_id),
    .ent_attr  (a_rd),
    .ent_id    (q_rd),
    .key_first (key_first)
  );

  always_comb begin
    q_re    = 1'b0;
    q_raddr = head;
    q_we    = 1'b0;
    q_waddr = head;
    q_wdata = ins_id;
    a_re    = 1'b0;
    a_raddr = running_task;
    a_we    = 1'b0;
    a_waddr = ins_id;
    a_wdata = new_attr;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (req_type)
            REQ_NEW: begin
              if (next_id != CW'(TASKS)) begin
                a_we    = 1'b1;
                a_waddr = next_id[AW-1:0];
              end
            end
            REQ_CONT: begin
              a_re = running_valid;
            end
            REQ_DISPATCH: begin
              q_re = (count != '0);
            end
            default: ;
          endcase
        end
      end
      S_CRD: begin
        a_we          = 1'b1;
        a_wdata       = a_rd;
        a_wdata.ready = key_attr.ready;
      end
      S_SQ: begin
        if (pos != count) begin
          q_re    = 1'b1;
          q_raddr = qwrap(head, pos);
        end
      end
      S_SA, S_DQ: begin
        a_re    = 1'b1;
        a_raddr = q_rd;
      end
      S_SHR: begin
        if (k == pos) begin
          q_we    = 1'b1;
          q_waddr = qwrap(head, pos);
        end else begin
          q_re    = 1'b1;
          q_raddr = qwrap(head, k - cnt_t'(1));
        end
      end
      S_SHW: begin
        q_we    = 1'b1;
        q_waddr = qwrap(head, k);
        q_wdata = q_rd;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_we) begin
      qmem[q_waddr] <= q_wdata;
    end
    if (q_re) begin
      q_rd <= qmem[q_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (a_we) begin
      amem[a_waddr] <= a_wdata;
    end
    if (a_re) begin
      a_rd <= amem[a_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      order_policy  <= POL_FIFO;
      now           <= '0;
      next_id       <= '0;
      running_valid <= 1'b0;
      running_task  <= '0;
      count         <= '0;
      head          <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        order_policy <= cfg_data;
      end
      if (out_valid && !out_stall && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            pos <= '0;
            case (req_type)
              REQ_NEW: begin
                if (next_id == CW'(TASKS)) begin
                  res_status <= STAT_FULL;
                  res_id     <= '0;
                  state      <= S_FIN;
                end else begin
                  res_status <= STAT_OK;
                  ins_id     <= next_id[AW-1:0];
                  res_id     <= next_id[AW-1:0];
                  key_attr   <= new_attr;
                  next_id    <= next_id + cnt_t'(1);
                  state      <= S_SQ;
                end
              end
              REQ_CONT: begin
                res_id <= '0;
                if (!running_valid) begin
                  res_status <= STAT_NO_RUN;
                  state      <= S_FIN;
                end else begin
                  res_status     <= STAT_OK;
                  running_valid  <= 1'b0;
                  ins_id         <= running_task;
                  key_attr.ready <= sat_add(now, wait_ticks);
                  state          <= S_CRD;
                end
              end
              REQ_ELAPSE: begin
                res_status <= STAT_OK;
                res_id     <= '0;
                now        <= sat_add(now, elapsed_ticks);
                state      <= S_FIN;
              end
              default: begin
                res_id <= '0;
                if (count == '0) begin
                  res_status <= STAT_EMPTY;
                  state      <= S_FIN;
                end else begin
                  res_status <= STAT_OK;
                  state      <= S_DQ;
                end
              end
            endcase
          end
        end
        S_CRD: begin
          key_attr <= a_wdata;
          state    <= S_SQ;
        end
        S_SQ: begin
          if (pos == count) begin
            k     <= count;
            state <= S_SHR;
          end else begin
            state <= S_SA;
          end
        end
        S_SA: begin
          state <= S_SC;
        end
        S_SC: begin
          if (key_first) begin
            k     <= count;
            state <= S_SHR;
          end else begin
            pos   <= pos + cnt_t'(1);
            state <= S_SQ;
          end
        end
        S_SHR: begin
          if (k == pos) begin
            count <= count + cnt_t'(1);
            state <= S_FIN;
          end else begin
            state <= S_SHW;
          end
        end
        S_SHW: begin
          k     <= k - cnt_t'(1);
          state <= S_SHR;
        end
        S_DQ: begin
          state <= S_DA;
        end
        S_DA: begin
          if (a_rd.ready > now) begin
            now <= a_rd.ready;
          end
          head          <= qwrap(head, cnt_t'(1));
          count         <= count - cnt_t'(1);
          running_valid <= 1'b1;
          running_task  <= q_rd;
          res_id        <= q_rd;
          state         <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            status    <= res_status;
            task_id   <= res_id;
            now_time  <= now;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(TASKS))
    else $error("queue count beyond capacity");

  a_ids_issued: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, count} + (CW + 1)'(running_valid)) <= {1'b0, next_id})
    else $error("more live tasks than issued ids");

  a_run_issued: assert property (@(posedge clk) disable iff (rst)
    running_valid |-> ({1'b0, running_task} < (AW + 1)'(next_id)))
    else $error("running task id never issued");

  a_scan_pos: assert property (@(posedge clk) disable iff (rst)
    (state == S_SQ || state == S_SC) |-> (pos <= count))
    else $error("scan position past queue end");

  a_out_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_FIN))
    else $error("result presented outside finish step");

endmodule

FILE: bench/potq_checker.sv
// Checker for the policy ordered task queue: follows the request, result and
// policy ports, keeps its own copy of the scheduler and compares every result.
// Depends on potq_pkg.
`timescale 1ns / 1ps
module potq_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  potq_pkg::policy_t  cfg_data,
  input  logic               in_valid,
  input  logic               in_stall,
  input  potq_pkg::req_t     req_type,
  input  logic signed [15:0] task_priority,
  input  logic [30:0]        task_deadline,
  input  logic               has_deadline,
  input  logic [15:0]        wait_ticks,
  input  logic [15:0]        elapsed_ticks,
  input  logic               out_valid,
  input  logic               out_stall,
  input  potq_pkg::stat_t    status,
  input  potq_pkg::id_t      task_id,
  input  potq_pkg::tick_t    now_time,
  output int                 mismatches,
  output int                 awaiting,
  output int                 results_checked,
  output logic [3:0]         statuses_seen,
  output logic               time_saturated
);
  import potq_pkg::*;

  typedef struct packed {
    stat_t st;
    id_t   id;
    tick_t t;
  } sched_result_t;

  sched_result_t      sched_results[$];
  policy_t            policy_q;
  tick_t              clock_now;
  int                 ids_used;
  logic               busy;
  id_t                busy_id;
  id_t                ready_list[$];
  logic signed [15:0] prio_of[TASKS];
  logic [30:0]        dl_of[TASKS];
  tick_t              rdy_of[TASKS];
  int                 fails;
  int                 checked;

  function automatic tick_t add_ticks(tick_t a, logic [15:0] b);
    if (a > TIME_MAX - tick_t'(b)) begin
      return TIME_MAX;
    end
    return a + tick_t'(b);
  endfunction

  // strict precedence of task a over task b under the current policy
  function automatic logic runs_ahead(id_t a, id_t b);
    case (policy_q)
      POL_PRIO: begin
        if (prio_of[a] != prio_of[b]) return prio_of[a] < prio_of[b];
      end
      POL_DEADLINE: begin
        if (dl_of[a] != dl_of[b]) return dl_of[a] < dl_of[b];
        if (rdy_of[a] != rdy_of[b]) return rdy_of[a] < rdy_of[b];
        if (prio_of[a] != prio_of[b]) return prio_of[a] < prio_of[b];
      end
      default: ;
    endcase
    return a < b;
  endfunction

  // goes behind every entry it does not strictly beat
  function automatic void file_task(id_t id);
    int pos;
    if (ready_list.size() >= TASKS) return;
    pos = 0;
    while (pos < ready_list.size() && !runs_ahead(id, ready_list[pos])) pos++;
    ready_list.insert(pos, id);
  endfunction

  function automatic sched_result_t schedule_request(req_t r, logic signed [15:0] p,
                                                     logic [30:0] d, logic hd,
                                                     logic [15:0] w, logic [15:0] e);
    sched_result_t res;
    id_t           head;
    res.st = STAT_OK;
    res.id = '0;
    case (r)
      REQ_NEW: begin
        if (ids_used >= TASKS) begin
          res.st = STAT_FULL;
        end else begin
          res.id = id_t'(ids_used);
          ids_used++;
          prio_of[res.id] = p;
          dl_of[res.id]   = hd ? d : NO_DEADLINE;
          rdy_of[res.id]  = '0;
          file_task(res.id);
        end
      end
      REQ_CONT: begin
        if (!busy) begin
          res.st = STAT_NO_RUN;
        end else begin
          busy = 1'b0;
          rdy_of[busy_id] = add_ticks(clock_now, w);
          file_task(busy_id);
        end
      end
      REQ_ELAPSE: begin
        clock_now = add_ticks(clock_now, e);
      end
      REQ_DISPATCH: begin
        if (ready_list.size() == 0) begin
          res.st = STAT_EMPTY;
        end else begin
          head = ready_list.pop_front();
          if (rdy_of[head] > clock_now) clock_now = rdy_of[head];
          busy    = 1'b1;
          busy_id = head;
          res.id  = head;
        end
      end
      default: ;
    endcase
    res.t = clock_now;
    return res;
  endfunction

  always @(posedge clk) begin : track
    sched_result_t want;
    if (rst) begin
      policy_q  = POL_FIFO;
      clock_now = '0;
      ids_used  = 0;
      busy      = 1'b0;
      busy_id   = '0;
      fails     = 0;
      checked   = 0;
      ready_list.delete();
      sched_results.delete();
      statuses_seen  <= '0;
      time_saturated <= 1'b0;
    end else begin
      if (cfg_we) policy_q = cfg_data;
      if (in_valid && !in_stall) begin
        want = schedule_request(req_type, task_priority, task_deadline, has_deadline,
                                wait_ticks, elapsed_ticks);
        sched_results.push_back(want);
        statuses_seen[want.st] <= 1'b1;
        if (clock_now == TIME_MAX) time_saturated <= 1'b1;
      end
      if (out_valid && !out_stall) begin
        checked++;
        if (sched_results.size() == 0) begin
          fails++;
          if (fails <= 10) begin
            $display("ERROR: unexpected result: status %0d id %0d now %0h",
                     status, task_id, now_time);
          end
        end else begin
          want = sched_results.pop_front();
          if (status !== want.st || task_id !== want.id || now_time !== want.t) begin
            fails++;
            if (fails <= 10) begin
              $display("ERROR: result %0d: expected status %0d id %0d now %0h, got status %0d id %0d now %0h",
                       checked, want.st, want.id, want.t, status, task_id, now_time);
            end
          end
        end
      end
    end
    mismatches      <= fails;
    awaiting        <= sched_results.size();
    results_checked <= checked;
  end

endmodule

FILE: bench/tb_policy_ordered_task_queue_core.sv
// Testbench top for policy_ordered_task_queue_core: clock, reset, request and
// policy stimulus, result-side stalls, and the final verdict.
// Depends on potq_pkg, potq_checker and the core.
`timescale 1ns / 1ps
module tb_policy_ordered_task_queue_core;
  import potq_pkg::*;

  localparam int      CYCLE_LIMIT = 8_000_000;
  localparam int      PHASE_ITEMS = 380;
  localparam int      SAT_ITEMS   = 40;
  localparam int      HOLD_CYCLES = 300;
  localparam policy_t POL_UNUSED  = 2'd3;

  logic               clk;
  logic               rst;
  logic               cfg_we;
  policy_t            cfg_data;
  logic               in_valid;
  logic               in_stall;
  req_t               req_type;
  logic signed [15:0] task_priority;
  logic [30:0]        task_deadline;
  logic               has_deadline;
  logic [15:0]        wait_ticks;
  logic [15:0]        elapsed_ticks;
  logic               out_valid;
  logic               out_stall;
  stat_t              status;
  id_t                task_id;
  tick_t              now_time;

  int         mismatches;
  int         awaiting;
  int         results_checked;
  logic [3:0] statuses_seen;
  logic       time_saturated;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_pending   = 1'b0;
  int cycles         = 0;
  int sent           = 0;

  policy_ordered_task_queue_core u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .req_type      (req_type),
    .task_priority (task_priority),
    .task_deadline (task_deadline),
    .has_deadline  (has_deadline),
    .wait_ticks    (wait_ticks),
    .elapsed_ticks (elapsed_ticks),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .task_id       (task_id),
    .now_time      (now_time)
  );

  potq_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .req_type        (req_type),
    .task_priority   (task_priority),
    .task_deadline   (task_deadline),
    .has_deadline    (has_deadline),
    .wait_ticks      (wait_ticks),
    .elapsed_ticks   (elapsed_ticks),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .status          (status),
    .task_id         (task_id),
    .now_time        (now_time),
    .mismatches      (mismatches),
    .awaiting        (awaiting),
    .results_checked (results_checked),
    .statuses_seen   (statuses_seen),
    .time_saturated  (time_saturated)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TIMEOUT after %0d cycles, %0d results pending", cycles, awaiting);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin : receiver
    int held;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        out_stall <= 1'b1;
        for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk);
        hold_pending = 1'b0;
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // valid stays high after a transaction unless a gap is chosen next
  task automatic send_req(req_t r, logic signed [15:0] p, logic [30:0] d, logic hd,
                          logic [15:0] w, logic [15:0] e);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    req_type      <= r;
    task_priority <= p;
    task_deadline <= d;
    has_deadline  <= hd;
    wait_ticks    <= w;
    elapsed_ticks <= e;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  // small values make ties in priority, deadline and ready time common
  task automatic send_random(req_t r);
    logic signed [15:0] p;
    logic [30:0]        d;
    logic [15:0]        w;
    logic [15:0]        e;
    p = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(4) - 2);
    case ($urandom_range(3))
      0: d = 31'($urandom);
      1: d = 31'($urandom_range(3));
      2: d = $urandom_range(1) ? NO_DEADLINE : NO_DEADLINE - 31'd1;
      default: d = 31'($urandom_range(40));
    endcase
    w = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(3));
    e = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(20));
    send_req(r, p, d, 1'($urandom), w, e);
  endtask

  task automatic settle(int tail);
    int n;
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
    for (n = 0; n < tail; n++) @(posedge clk);
  endtask

  task automatic set_policy(policy_t p);
    settle(4);
    cfg_we   <= 1'b1;
    cfg_data <= p;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // mostly dispatch/continue pairs so tasks keep cycling through the queue
  task automatic run_phase(policy_t pol, int snd, int rcv, int n);
    int k;
    int pick;
    set_policy(pol);
    send_idle_pct  = snd;
    recv_stall_pct = rcv;
    k = 0;
    while (k < n) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        send_random(REQ_DISPATCH);
        if ($urandom_range(3) == 0) send_random(REQ_ELAPSE);
        send_random(REQ_CONT);
        k += 2;
      end else begin
        if (pick < 64) send_random(REQ_NEW);
        else if (pick < 78) send_random(REQ_ELAPSE);
        else if (pick < 81) send_random(REQ_DISPATCH);
        else if (pick < 88) send_random(REQ_CONT);
        else send_random(req_t'($urandom_range(3)));
        k++;
      end
    end
  endtask

  initial begin : stimulus
    int i;
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_data      = POL_FIFO;
    in_valid      = 1'b0;
    req_type      = REQ_ELAPSE;
    task_priority = '0;
    task_deadline = '0;
    has_deadline  = 1'b0;
    wait_ticks    = '0;
    elapsed_ticks = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    set_policy(POL_FIFO);
    send_req(REQ_DISPATCH, 16'sd0, 31'd0, 1'b0, 16'd0, 16'd0);
    send_req(REQ_CONT, 16'sd0, 31'd0, 1'b0, 16'd0, 16'd0);
    send_req(REQ_ELAPSE, 16'sd0, 31'd0, 1'b0, 16'd0, 16'd0);
    send_req(REQ_NEW, 16'sh7FFF, 31'd0, 1'b1, 16'd0, 16'd0);
    send_req(REQ_NEW, -16'sh8000, NO_DEADLINE, 1'b1, 16'hFFFF, 16'hFFFF);
    send_req(REQ_NEW, 16'sd0, 31'h1234_5678, 1'b0, 16'd0, 16'd0);
    send_req(REQ_NEW, -16'sd1, 31'd1, 1'b1, 16'd0, 16'd0);
    send_req(REQ_ELAPSE, 16'sd0, 31'd0, 1'b0, 16'd0, 16'hFFFF);
    send_req(REQ_DISPATCH, 16'sd0, 31'd0, 1'b0, 16'd0, 16'd0);
    send_req(REQ_DISPATCH, 16'sd0, 31'd0, 1'b0, 16'd0, 16'd0);
    send_req(REQ_CONT, 16'sd0, 31'd0, 1'b0, 16'hFFFF, 16'd0);
    send_req(REQ_CONT, 16'sd0, 31'd0, 1'b0, 16'd0, 16'd0);
    send_req(REQ_DISPATCH, 16'sd0, 31'd0, 1'b0, 16'd0, 16'd0);
    send_req(REQ_CONT, 16'sd0, 31'd0, 1'b0, 16'd0, 16'd0);
    send_req(REQ_ELAPSE, 16'sd0, 31'd0, 1'b0, 16'd0, 16'd1);
    set_policy(POL_PRIO);
    send_req(REQ_NEW, 16'sd5, 31'd0, 1'b0, 16'd0, 16'd0);
    send_req(REQ_NEW, 16'sd5, 31'd0, 1'b0, 16'd0, 16'd0);
    send_req(REQ_DISPATCH, 16'sd0, 31'd0, 1'b0, 16'd0, 16'd0);
    set_policy(POL_DEADLINE);
    send_req(REQ_NEW, 16'sd5, 31'd0, 1'b1, 16'd0, 16'd0);
    send_req(REQ_NEW, 16'sd5, 31'd0, 1'b1, 16'd0, 16'd0);
    send_req(REQ_CONT, 16'sd0, 31'd0, 1'b0, 16'd3, 16'd0);
    send_req(REQ_DISPATCH, 16'sd0, 31'd0, 1'b0, 16'd0, 16'd0);
    send_req(REQ_DISPATCH, 16'sd0, 31'd0, 1'b0, 16'd0, 16'd0);

    hold_pending = 1'b1;
    run_phase(POL_PRIO, 0, 0, PHASE_ITEMS);
    run_phase(POL_DEADLINE, 83, 0, PHASE_ITEMS);
    run_phase(POL_UNUSED, 0, 83, PHASE_ITEMS);
    run_phase(POL_DEADLINE, 16, 16, PHASE_ITEMS);

    // push the clock forward with long elapses, then keep scheduling there
    set_policy(POL_DEADLINE);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    for (i = 0; i < SAT_ITEMS; i++) begin
      send_req(REQ_ELAPSE, 16'($urandom), 31'($urandom), 1'($urandom),
               16'($urandom), 16'hFFFF);
    end
    run_phase(POL_DEADLINE, 16, 16, 120);
    run_phase(POL_FIFO, 0, 0, 60);
    run_phase(POL_PRIO, 0, 0, 60);

    settle(400);
    $display("Sent %0d requests, %0d results compared, across fifo, priority, deadline and the spare policy code.",
             sent, results_checked);
    $display("Statuses seen (full/no-run/empty/ok) %b, clock saturated %0d",
             statuses_seen, time_saturated);
    if (mismatches == 0 && awaiting == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/potq_pkg.sv
src/potq_order.sv
src/policy_ordered_task_queue_core.sv
bench/potq_checker.sv
bench/tb_policy_ordered_task_queue_core.sv
